// ===== hdl/lcg48_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_pkg
// Shared types, constants and helpers of the 48-bit LCG bounded random core.
// ----------------------------------------------------------------------------
package lcg48_pkg;

  localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;

  localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD  = 48'h0000_0000_000B;

  // multiplier split into two 24-bit halves for the partial products
  localparam logic [23:0] MULT_LO = LCG_MULT[23:0];
  localparam logic [23:0] MULT_HI = LCG_MULT[47:24];

  localparam logic [4:0]  DIV_LAST = 5'd30;

  typedef enum logic [1:0] {
    CLS_NONPOS,
    CLS_POW2,
    CLS_GENERAL
  } req_cls_t;

  typedef struct packed {
    req_cls_t    cls;
    logic [30:0] bound;
  } req_t;

  typedef struct packed {
    logic        load;
    logic [47:0] state;
  } seed_load_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_DIV,
    BK_CHECK,
    BK_FIN
  } back_state_t;

  // sign-extend seed and scramble with the multiplier
  function automatic logic [47:0] scramble_seed(input logic [31:0] seed);
    return {{16{seed[31]}}, seed} ^ LCG_MULT;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/lcg48_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48 channel interfaces
// Valid/ready channels for requests and results of the random core.
// ----------------------------------------------------------------------------
interface lcg48_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] upper_bound;

  modport source (output valid, output upper_bound, input ready);
  modport sink   (input valid, input upper_bound, output ready);
endinterface

interface lcg48_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/lcg48_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_front
// Accept requests and classify the bound for the back end.
// ----------------------------------------------------------------------------
module lcg48_front import lcg48_pkg::*; (
  lcg48_in_if.sink in_req,
  input  logic     q_full,
  output logic     q_push,
  output req_t     q_entry
);

  logic [31:0] bound;
  logic [31:0] lowest;

  assign bound  = in_req.upper_bound;
  assign lowest = bound & (~bound + 32'd1);

  assign in_req.ready = !q_full;
  assign q_push       = in_req.valid && !q_full;

  always_comb begin
    q_entry.bound = bound[30:0];
    if (bound[31] || (bound == 32'd0)) begin
      q_entry.cls = CLS_NONPOS;
    end else if (lowest == bound) begin
      q_entry.cls = CLS_POW2;
    end else begin
      q_entry.cls = CLS_GENERAL;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/lcg48_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_queue
// Small FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module lcg48_queue import lcg48_pkg::*; #(
  parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  req_t wr_data,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t rd_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  req_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_W'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue popped while empty");

endmodule
`default_nettype wire

// ===== hdl/lcg48_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// lcg48_back
// Draw sequencer: split LCG multiply, power-of-two scaling or bit-serial modulo, rejection, result.
// ----------------------------------------------------------------------------
module lcg48_back import lcg48_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  seed_load_t  seed,
  input  logic        q_empty,
  input  req_t        q_head,
  output logic        q_pop,
  lcg48_out_if.source out_res
);

  back_state_t state_r, state_nxt;

  logic [47:0] lcg_state_r, lcg_state_nxt;
  logic [47:0] acc_r, acc_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic [1:0]  step_r, step_nxt;
  req_t        req_r, req_nxt;
  logic [30:0] draw_r, draw_nxt;
  logic [30:0] div_q_r, div_q_nxt;
  logic [30:0] rem_r, rem_nxt;
  logic [4:0]  div_cnt_r, div_cnt_nxt;
  logic [61:0] scale_r, scale_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [30:0] out_value_r, out_value_nxt;

  logic [23:0] mul_a, mul_b;
  logic [47:0] mul_p, add_term, acc_sum;
  logic [61:0] scale_p;
  logic [31:0] div_shift;
  logic [32:0] div_diff;
  logic [31:0] reject_sum;
  logic        reject;
  logic        out_free;
  logic [30:0] fin_value;

  assign mul_a    = (step_r == 2'd2) ? lcg_state_r[47:24] : lcg_state_r[23:0];
  assign mul_b    = (step_r == 2'd1) ? MULT_HI : MULT_LO;
  assign mul_p    = mul_a * mul_b;
  // low partial product adds in place, cross products sit 24 bits up
  assign add_term = (step_r == 2'd1) ? prod_r : {prod_r[23:0], 24'd0};
  assign acc_sum  = acc_r + add_term;

  assign scale_p  = req_r.bound * draw_r;

  assign div_shift = {rem_r, div_q_r[30]};
  assign div_diff  = {1'b0, div_shift} - {2'b00, req_r.bound};

  assign reject_sum = {1'b0, draw_r} - {1'b0, rem_r} + {1'b0, req_r.bound} - 32'd1;
  assign reject     = reject_sum[31];

  assign out_free = !out_valid_r || out_res.ready;

  always_comb begin
    case (req_r.cls)
      CLS_POW2:    fin_value = scale_r[61:31] + 31'd1;
      CLS_GENERAL: fin_value = rem_r + 31'd1;
      default:     fin_value = 31'd1;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (q_head.cls == CLS_NONPOS) ? BK_FIN : BK_MUL;
        end
      end
      BK_MUL: begin
        if (step_r == 2'd3) begin
          state_nxt = (req_r.cls == CLS_POW2) ? BK_SCALE : BK_DIV;
        end
      end
      BK_SCALE: state_nxt = BK_FIN;
      BK_DIV: begin
        if (div_cnt_r == DIV_LAST) begin
          state_nxt = BK_CHECK;
        end
      end
      BK_CHECK: state_nxt = reject ? BK_MUL : BK_FIN;
      BK_FIN: begin
        if (out_free) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    lcg_state_nxt = lcg_state_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    step_nxt      = step_r;
    req_nxt       = req_r;
    draw_nxt      = draw_r;
    div_q_nxt     = div_q_r;
    rem_nxt       = rem_r;
    div_cnt_nxt   = div_cnt_r;
    scale_nxt     = scale_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    out_value_nxt = out_value_r;

    case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          req_nxt  = q_head;
          acc_nxt  = LCG_ADD;
          step_nxt = 2'd0;
        end
      end
      BK_MUL: begin
        prod_nxt = mul_p;
        step_nxt = step_r + 2'd1;
        if (step_r != 2'd0) begin
          acc_nxt = acc_sum;
        end
        if (step_r == 2'd3) begin
          lcg_state_nxt = acc_sum;
          draw_nxt      = acc_sum[47:17];
          div_q_nxt     = acc_sum[47:17];
          rem_nxt       = '0;
          div_cnt_nxt   = '0;
        end
      end
      BK_SCALE: scale_nxt = scale_p;
      BK_DIV: begin
        rem_nxt     = div_diff[32] ? div_shift[30:0] : div_diff[30:0];
        div_q_nxt   = {div_q_r[29:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
      end
      BK_CHECK: begin
        if (reject) begin
          acc_nxt  = LCG_ADD;
          step_nxt = 2'd0;
        end
      end
      BK_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = fin_value;
        end
      end
      default: ;
    endcase

    if (seed.load) begin
      lcg_state_nxt = seed.state;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      lcg_state_r <= LCG_MULT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcg_state_r <= lcg_state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    step_r      <= step_nxt;
    req_r       <= req_nxt;
    draw_r      <= draw_nxt;
    div_q_r     <= div_q_nxt;
    rem_r       <= rem_nxt;
    div_cnt_r   <= div_cnt_nxt;
    scale_r     <= scale_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_res.valid        = out_valid_r;
  assign out_res.random_value = out_value_r;

  a_state_moves_on_draw: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(lcg_state_r) |->
      ($past(state_r == BK_MUL && step_r == 2'd3) || $past(seed.load)))
    else $error("generator state changed outside a draw or seed load");

  a_rem_below_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < req_r.bound)
    else $error("partial remainder not below bound");

  a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_value_r != 31'd0)
    else $error("result of zero presented");

endmodule
`default_nettype wire

// ===== hdl/lcg48_bounded_random_core.sv =====
`default_nettype none
// Request path: a bound of zero or less skips the generator, a power of two scales one draw,
//   and any other bound reduces a draw and redraws after each rejection (each such draw is a
//   split multiply, a bit-serial modulo and one rejection check).
// Sequencing: one request at a time in the draw sequencer; a QUEUE_DEPTH queue buffers input.
//   The sequencer holds each finished result until the output register is free.
// Reset: rst_n synchronous active low; seed register 0, generator state 0x5DEECE66D.
// ----------------------------------------------------------------------------
// lcg48_bounded_random_core
// Bounded random integer generator on a 48-bit linear congruential generator.
// ----------------------------------------------------------------------------
module lcg48_bounded_random_core import lcg48_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  lcg48_in_if.sink    in_req,
  lcg48_out_if.source out_res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // Front end: classify each request (nonpositive, power of two, general)
  // and push it into the queue; ready simply reflects queue space.
  logic q_push, q_full, q_pop, q_empty;
  req_t q_wr, q_head;

  lcg48_front u_front (
    .in_req  (in_req),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_entry (q_wr)
  );

  lcg48_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  // Configuration: one register, the seed. The only register sits at
  // offset zero and the address bits are not decoded, so every
  // completed write lands on it. A write reloads the generator state with the
  // sign-extended seed XORed with the multiplier.
  logic [31:0] seed_value_r, seed_value_nxt;
  logic        cfg_wr;
  seed_load_t  seed;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[1:0] == paddr[1:0]);
  assign prdata = seed_value_r;

  assign seed_value_nxt = cfg_wr ? pwdata : seed_value_r;
  assign seed.load      = cfg_wr;
  assign seed.state     = scramble_seed(pwdata);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_value_r <= '0;
    end else begin
      seed_value_r <= seed_value_nxt;
    end
  end

  // Back end: pop a request, advance the generator, reduce the draw, reject
  // and redraw where needed, and hold the result in the output register.
  lcg48_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .seed    (seed),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule
`default_nettype wire

// ===== tb/sv/lcg48_draw_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lcg48_draw_checker
// Watches the request, result and seed-write traffic of the bounded random
// core. It keeps its own 48-bit generator state, predicts each result value
// as requests are accepted, and compares the results in order.
// ----------------------------------------------------------------------------
module lcg48_draw_checker (
  input  logic        clk,
  input  logic        rst_n,
  lcg48_in_if         req,
  lcg48_out_if        res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output int          errors,
  output int          pending
);

  localparam logic [47:0] GEN_MUL   = 48'h0005_DEEC_E66D;
  localparam logic [47:0] GEN_INC   = 48'h0000_0000_000B;
  localparam logic [1:0]  SEED_ADDR = 2'd0;
  localparam int unsigned EXP_DEPTH = 64;

  logic [47:0] gen_state;
  logic [30:0] expected_values [EXP_DEPTH];
  int unsigned exp_wr = 0;
  int unsigned exp_rd = 0;
  int          error_tally = 0;

  // sign-extend to 48 bits, then scramble with the multiplier
  function automatic logic [47:0] seeded_state(input logic [31:0] seed);
    return {{16{seed[31]}}, seed} ^ GEN_MUL;
  endfunction

  // advance the generator and return its top 31 bits
  function automatic logic [31:0] next_draw();
    gen_state = gen_state * GEN_MUL + GEN_INC;
    return {1'b0, gen_state[47:17]};
  endfunction

  function automatic logic [30:0] predict_random_value(input logic signed [31:0] bound);
    logic [31:0] b;
    logic [31:0] d;
    logic [31:0] r;
    logic [31:0] sum;
    logic [63:0] prod;
    b = bound;
    if (bound <= 0)
      return 31'd1;
    if ((b & (~b + 32'd1)) == b) begin
      d    = next_draw();
      prod = {32'd0, b} * {32'd0, d};
      return prod[61:31] + 31'd1;
    end
    // reject draws from the incomplete top slice of the range
    do begin
      d   = next_draw();
      r   = d % b;
      sum = d - r + (b - 32'd1);
    end while (sum[31]);
    return r[30:0] + 31'd1;
  endfunction

  always @(posedge clk) begin : monitor
    logic [30:0] want;
    if (!rst_n) begin
      gen_state = seeded_state(32'd0);
      exp_wr    = 0;
      exp_rd    = 0;
    end else begin
      if (res.valid && res.ready) begin
        if (exp_wr == exp_rd) begin
          $error("random_value: expected none, got %0d", res.random_value);
          error_tally++;
        end else begin
          want = expected_values[exp_rd % EXP_DEPTH];
          exp_rd++;
          if (res.random_value !== want) begin
            $error("random_value: expected %0d, got %0d", want, res.random_value);
            error_tally++;
          end
        end
      end
      if (psel && penable && pwrite && pready && paddr == SEED_ADDR)
        gen_state = seeded_state(pwdata);
      if (req.valid && req.ready) begin
        expected_values[exp_wr % EXP_DEPTH] = predict_random_value(req.upper_bound);
        exp_wr++;
      end
    end
    errors  <= error_tally;
    pending <= int'(exp_wr - exp_rd);
  end

endmodule

// ===== tb/sv/tb_lcg48_bounded_random_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcg48_bounded_random_core
// Drives bound requests into the random core under random handshake gaps,
// reloads the seed between phases, and lets the draw checker compare every
// result against its own generator model.
// ----------------------------------------------------------------------------
module tb_lcg48_bounded_random_core;

  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned PHASE_REQUESTS = 204;
  localparam int unsigned MAX_WAIT       = 18;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned TAIL_CYCLES    = 60;
  localparam logic [1:0]  SEED_ADDR      = 2'd0;

  typedef enum int {
    IDLE_NONE,
    IDLE_SHORT,
    IDLE_FULL
  } idle_mode_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [1:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int unsigned cycle_count = 0;
  int          fail_count;
  int          pending_results;
  idle_mode_t  send_mode;
  idle_mode_t  take_mode;

  lcg48_in_if  req_ch ();
  lcg48_out_if res_ch ();

  lcg48_bounded_random_core uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_res (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  lcg48_draw_checker draw_check (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (fail_count),
    .pending (pending_results)
  );

  always #5 clk = ~clk;

  // Drop the run once the cycle limit is reached, as when the core stops making progress.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Idle length for one request or result, shaped by the current mode.
  function automatic int unsigned idle_cycles(input idle_mode_t mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_SHORT: return $urandom_range(0, 2);
      default:    return $urandom_range(0, MAX_WAIT);
    endcase
  endfunction

  // Half the time full random gaps, otherwise back-to-back or near it.
  function automatic idle_mode_t pick_mode();
    case ($urandom_range(0, 3))
      0:       return IDLE_NONE;
      1:       return IDLE_SHORT;
      default: return IDLE_FULL;
    endcase
  endfunction

  // Random bound: spread over the nonpositive, power-of-two, small,
  // rejection-heavy and full-range classes so every bit toggles.
  function automatic logic signed [31:0] random_bound();
    case ($urandom_range(0, 9))
      0:       return ($urandom_range(0, 7) == 0) ? 32'd0 : {1'b1, 31'($urandom)};
      1, 2:    return 32'd1 << $urandom_range(0, 30);
      3, 4:    return $urandom_range(1, 1000);
      5:       return 32'h4000_0000 + $urandom_range(1, 32'h3FFF_FFFF);
      6, 7:    return {1'b0, 31'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  // Present one request and hold it until the core takes it. Valid stays
  // high across back-to-back requests; lower it only ahead of a gap.
  task automatic send_request(input logic signed [31:0] bound);
    int unsigned gap;
    gap = idle_cycles(send_mode);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.upper_bound <= bound;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Wait until every predicted result has come back, then let the core settle.
  task automatic drain_results();
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the seed lands when pready is seen.
  task automatic write_seed(input logic [31:0] seed);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SEED_ADDR;
    pwdata  <= seed;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: stall ready at random, switching modes every so often.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    forever begin
      if (taken % 50 == 0)
        take_mode = pick_mode();
      stall = idle_cycles(take_mode);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    logic signed [31:0] directed_bounds [$];
    logic [31:0]        seeds [$];
    rst_n              <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= SEED_ADDR;
    pwdata             <= 32'd0;
    req_ch.valid       <= 1'b0;
    req_ch.upper_bound <= 32'd0;
    send_mode = IDLE_FULL;

    // Zero, negative and most-negative bounds give 1 and keep the state;
    // powers of two take one scaled draw; the rest go through the modulo
    // path, with bounds just above 2^30 and 3*2^29 forcing rejections.
    directed_bounds = '{
      32'sd0, -32'sd1, 32'h8000_0000, 32'hAAAA_AAAA,
      32'sd1, 32'sd2, 32'sd4, 32'h2000_0000, 32'h4000_0000,
      32'sd3, 32'sd5, 32'sd7, 32'sd100, 32'sd1000, 32'sd65535, 32'sd65536,
      32'h4000_0001, 32'h4000_0003, 32'h6000_0000, 32'h5555_5555,
      32'h1234_5678, 32'h7FFF_FFFE, 32'h7FFF_FFFF
    };

    // Hold reset once, at the start.
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run the directed set from the reset seed.
    foreach (directed_bounds[i])
      send_request(directed_bounds[i]);
    req_ch.valid <= 1'b0;

    // Seed extremes first (largest positive, most negative, all ones, zero),
    // then random seeds; reload only once the core has gone quiet.
    seeds = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
              $urandom, $urandom, $urandom, $urandom};
    foreach (seeds[p]) begin
      drain_results();
      write_seed(seeds[p]);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if (n % 40 == 0)
          send_mode = pick_mode();
        send_request(random_bound());
      end
      req_ch.valid <= 1'b0;
    end

    // Drain the last results and give the core a tail to misbehave in.
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
